>>> rtl/core/dtop_pkg.sv
// Shared types and constants for the DER header and object identifier parser.
package dtop_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN0,
    PH_LENX,
    PH_BODY,
    PH_IDLE
  } phase_t;

  // Record kinds.
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_COMP = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Item types.
  localparam logic [2:0] TY_NULL = 3'd0;
  localparam logic [2:0] TY_BITS = 3'd1;
  localparam logic [2:0] TY_OCTS = 3'd2;
  localparam logic [2:0] TY_OBJ  = 3'd3;
  localparam logic [2:0] TY_SEQ  = 3'd4;
  localparam logic [2:0] TY_CTX  = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_TAG     = 2'd2;
  localparam logic [1:0] ERR_LEN_OVF = 2'd3;

  // Tag fields and universal type codes.
  localparam logic [7:0] TAG_CLASS_MASK = 8'hC0;
  localparam logic [7:0] TAG_CLASS_CTX  = 8'h80;
  localparam logic [7:0] TAG_CLASS_UNIV = 8'h00;
  localparam logic [4:0] UT_BITS = 5'd3;
  localparam logic [4:0] UT_OCTS = 5'd4;
  localparam logic [4:0] UT_NULL = 5'd5;
  localparam logic [4:0] UT_OBJ  = 5'd6;
  localparam logic [4:0] UT_SEQ  = 5'd16;

  // The first identifier byte packs two arcs as first * 40 + second.
  localparam logic [7:0]  OID_ARC_DIV  = 8'd40;
  // floor(b * 205 / 8192) equals floor(b / 40) for every byte value.
  localparam logic [15:0] OID_RECIP    = 16'd205;
  localparam int          OID_RECIP_SH = 13;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  item_type;
    logic [31:0] content_length;
    logic [63:0] component_value;
    logic [1:0]  error_code;
    logic        last;
  } rec_t;

endpackage

>>> rtl/core/dtop_ifs.sv
// Valid/ready channel interfaces for the parser's byte input and record output.
interface dtop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface dtop_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [2:0]  item_type;
  logic [31:0] content_length;
  logic [63:0] component_value;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, output record_kind, output item_type,
                  output content_length, output component_value,
                  output error_code, output last, input ready);
  modport sink (input valid, input record_kind, input item_type,
                input content_length, input component_value,
                input error_code, input last, output ready);
endinterface

>>> rtl/core/der_tlv_oid_stream_parser.sv
// DER item header and object identifier parser: one byte per transaction.
//
// in_chan carries the item one byte at a time; end_of_data marks the last
// byte, and the byte after it is read as a new tag. out_chan delivers
// records: a header (type and content length), object identifier components
// for object items, or an error record, which always carries last.
// Each byte is decoded in the cycle it is accepted and its records are
// written into a four-entry output queue, so a record can reach out_chan in
// the cycle after the byte that caused it. A new byte is taken every cycle
// while the queue has two free entries; the first content byte of an object
// makes two records, so the sustained rate is one byte per cycle as long as
// the receiver takes one record per cycle. The queue's single read port sets
// the output rate at one record per cycle.
// When the receiver stalls, the queue fills and in_chan.ready drops once
// fewer than two entries are free; nothing is lost or reordered.
// Synchronous reset empties the queue and returns the parser to expecting a
// tag byte; no clearing pass is needed.
module der_tlv_oid_stream_parser #(
  parameter int MAX_LENGTH_BYTES = 4,
  parameter int SUBID_WIDTH      = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  dtop_in_if.sink    in_chan,
  dtop_out_if.source out_chan
);
  import dtop_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Parser state.
  phase_t                   phase_r, phase_nxt;
  logic [2:0]               type_r, type_nxt;
  logic [2:0]               lbl_r, lbl_nxt;
  logic [31:0]              accum_r, accum_nxt;
  logic [31:0]              content_r, content_nxt;
  logic                     first_r, first_nxt;
  logic [SUBID_WIDTH-1:0]   subid_r, subid_nxt;

  // Output queue.
  rec_t                     queue_r [QDEPTH];
  logic [QAW-1:0]           wr_r, rd_r;
  logic [QAW:0]             count_r;

  logic       accept, pop;
  logic [7:0] b;
  logic       eod;

  // Decode of the current byte.
  logic                   tag_ok;
  logic [2:0]             tag_type;
  logic [6:0]             len_cnt;
  logic                   hdr_fire;
  logic [31:0]            hdr_len;
  logic                   hdr_more;
  logic                   fail_fire;
  logic [1:0]             fail_code;
  logic                   enter_lenx;
  logic [31:0]            lenx_acc;
  logic [31:0]            body_left;
  logic                   body_done;
  logic [SUBID_WIDTH-1:0] subid_shift;
  logic [15:0]            recip_prod;
  logic [7:0]             arc_hi, arc_lo;

  // Records produced by this byte.
  logic [1:0] n_push;
  rec_t       rec0, rec1;

  assign b      = in_chan.data_byte;
  assign eod    = in_chan.end_of_data;
  assign accept = in_chan.valid && in_chan.ready;
  assign pop    = out_chan.valid && out_chan.ready;

  assign in_chan.ready = (count_r <= (QAW+1)'(QDEPTH - 2));

  always_comb begin
    tag_ok   = 1'b1;
    tag_type = TY_NULL;
    if ((b & TAG_CLASS_MASK) == TAG_CLASS_CTX) begin
      tag_type = TY_CTX;
    end else if ((b & TAG_CLASS_MASK) != TAG_CLASS_UNIV) begin
      tag_ok = 1'b0;
    end else begin
      case (b[4:0])
        UT_BITS: tag_type = TY_BITS;
        UT_OCTS: tag_type = TY_OCTS;
        UT_NULL: tag_type = TY_NULL;
        UT_OBJ:  tag_type = TY_OBJ;
        UT_SEQ:  tag_type = TY_SEQ;
        default: tag_ok = 1'b0;
      endcase
    end
  end

  assign len_cnt     = b[6:0];
  assign lenx_acc    = {accum_r[23:0], b};
  assign body_left   = content_r - 32'd1;
  assign body_done   = (body_left == 32'd0);
  assign subid_shift = {subid_r[SUBID_WIDTH-8:0], b[6:0]};
  assign recip_prod  = 16'(b) * OID_RECIP;
  assign arc_hi      = 8'(recip_prod[15:OID_RECIP_SH]);
  assign arc_lo      = 8'(b - arc_hi * OID_ARC_DIV);

  // Shared event decode: which header or error this byte raises.
  always_comb begin
    hdr_fire   = 1'b0;
    hdr_len    = 32'd0;
    fail_fire  = 1'b0;
    fail_code  = ERR_NONE;
    enter_lenx = 1'b0;
    case (phase_r)
      PH_TAG: begin
        if (eod) begin
          fail_fire = 1'b1;
          fail_code = ERR_TRUNC;
        end else if (!tag_ok) begin
          fail_fire = 1'b1;
          fail_code = ERR_TAG;
        end
      end
      PH_LEN0: begin
        if (!b[7]) begin
          hdr_fire = 1'b1;
          hdr_len  = {24'd0, b};
        end else if (len_cnt == 7'd0) begin
          hdr_fire = 1'b1;
        end else if (eod) begin
          fail_fire = 1'b1;
          fail_code = ERR_TRUNC;
        end else if (len_cnt > 7'(MAX_LENGTH_BYTES)) begin
          fail_fire = 1'b1;
          fail_code = ERR_LEN_OVF;
        end else begin
          enter_lenx = 1'b1;
        end
      end
      PH_LENX: begin
        if (accum_r[31:24] != 8'd0) begin
          fail_fire = 1'b1;
          fail_code = ERR_LEN_OVF;
        end else if (lbl_r == 3'd0) begin
          hdr_fire = 1'b1;
          hdr_len  = lenx_acc;
        end else if (eod) begin
          fail_fire = 1'b1;
          fail_code = ERR_TRUNC;
        end
      end
      PH_BODY: ;
      PH_IDLE: ;
      default: ;
    endcase
  end

  assign hdr_more = (type_r == TY_OBJ) && (hdr_len != 32'd0);

  // Next state.
  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    lbl_nxt     = lbl_r;
    accum_nxt   = accum_r;
    content_nxt = content_r;
    first_nxt   = first_r;
    subid_nxt   = subid_r;
    if (accept) begin
      if (fail_fire) begin
        phase_nxt = PH_IDLE;
      end else if (hdr_fire) begin
        accum_nxt   = hdr_len;
        content_nxt = hdr_len;
        first_nxt   = 1'b1;
        subid_nxt   = '0;
        phase_nxt   = hdr_more ? PH_BODY : PH_IDLE;
      end else begin
        case (phase_r)
          PH_TAG: begin
            type_nxt  = tag_type;
            phase_nxt = PH_LEN0;
          end
          PH_LEN0: begin
            if (enter_lenx) begin
              lbl_nxt   = 3'(len_cnt - 7'd1);
              accum_nxt = 32'd0;
              phase_nxt = PH_LENX;
            end
          end
          PH_LENX: begin
            accum_nxt = lenx_acc;
            lbl_nxt   = lbl_r - 3'd1;
          end
          PH_BODY: begin
            content_nxt = body_left;
            if (first_r) begin
              first_nxt = 1'b0;
            end else begin
              subid_nxt = b[7] ? subid_shift : '0;
            end
            if (body_done) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
      // The last byte of the data ends the item whatever the phase.
      if (eod) begin
        phase_nxt   = PH_TAG;
        type_nxt    = TY_NULL;
        lbl_nxt     = 3'd0;
        accum_nxt   = 32'd0;
        content_nxt = 32'd0;
        first_nxt   = 1'b1;
        subid_nxt   = '0;
      end
    end
  end

  // Records for this byte.
  always_comb begin
    n_push = 2'd0;
    rec0   = '0;
    rec1   = '0;
    if (accept) begin
      if (fail_fire) begin
        n_push           = 2'd1;
        rec0.record_kind = KIND_ERR;
        rec0.error_code  = fail_code;
        rec0.last        = 1'b1;
      end else if (hdr_fire) begin
        n_push              = 2'd1;
        rec0.record_kind    = KIND_HDR;
        rec0.item_type      = type_r;
        rec0.content_length = hdr_len;
        rec0.last           = !hdr_more;
      end else if (phase_r == PH_BODY) begin
        rec0.record_kind = KIND_COMP;
        rec0.item_type   = TY_OBJ;
        rec1.record_kind = KIND_COMP;
        rec1.item_type   = TY_OBJ;
        if (first_r) begin
          n_push               = 2'd2;
          rec0.component_value = 64'(arc_hi);
          rec1.component_value = 64'(arc_lo);
          rec1.last            = body_done;
        end else if (!b[7]) begin
          n_push               = 2'd1;
          rec0.component_value = 64'(subid_shift);
          rec0.last            = body_done;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG;
      type_r    <= TY_NULL;
      lbl_r     <= 3'd0;
      accum_r   <= 32'd0;
      content_r <= 32'd0;
      first_r   <= 1'b1;
      subid_r   <= '0;
      wr_r      <= '0;
      rd_r      <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      lbl_r     <= lbl_nxt;
      accum_r   <= accum_nxt;
      content_r <= content_nxt;
      first_r   <= first_nxt;
      subid_r   <= subid_nxt;
      wr_r      <= wr_r + QAW'(n_push);
      rd_r      <= rd_r + QAW'(pop);
      count_r   <= count_r + (QAW+1)'(n_push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_r] <= rec0;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_r + QAW'(1)] <= rec1;
    end
  end

  assign out_chan.valid           = (count_r != '0);
  assign out_chan.record_kind     = queue_r[rd_r].record_kind;
  assign out_chan.item_type       = queue_r[rd_r].item_type;
  assign out_chan.content_length  = queue_r[rd_r].content_length;
  assign out_chan.component_value = queue_r[rd_r].component_value;
  assign out_chan.error_code      = queue_r[rd_r].error_code;
  assign out_chan.last            = queue_r[rd_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("output queue overflow");

  a_eod_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eod) |=> (phase_r == PH_TAG))
    else $error("end of data did not restart the parser");

  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (content_r != 32'd0))
    else $error("content phase with nothing left");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.record_kind == KIND_ERR) |-> out_chan.last)
    else $error("error record without last");

endmodule
